@@ hdl/scte_pkg.sv @@
// Shared types and constants for the sprite column tile expander.
`default_nettype none
package scte_pkg;

   localparam int unsigned FLASH_BIT = 12;
   localparam int unsigned XFLIP_BIT = 13;
   localparam int unsigned YFLIP_BIT = 14;
   localparam int unsigned SIZE_LSB  = 9;
   localparam int unsigned COORD_W   = 9;
   localparam int unsigned POS_W     = 10;
   localparam int unsigned CODE_W    = 16;
   localparam int unsigned COLOUR_W  = 4;
   localparam int unsigned SLOT_W    = 3;
   localparam int unsigned COLOUR_LSB = 9;

   // x at or above this wraps to the negative side
   localparam logic [COORD_W-1:0] X_WRAP = 9'd320;

   // one decoded sprite, as handed from front to back
   typedef struct packed {
      logic [CODE_W-1:0]       base;
      logic [SLOT_W-1:0]       top;
      logic [COLOUR_W-1:0]     colour;
      logic                    flip_x;
      logic                    flip_y;
      logic                    code_up;
      logic signed [POS_W-1:0] x_pos;
      logic signed [POS_W-1:0] y_pos;
   } desc_type;

endpackage
`default_nettype wire

@@ hdl/scte_front.sv @@
// Front end: accepts sprite entries, drops flashing ones on odd frames, decodes the rest.
`default_nettype none
module scte_front (
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [15:0]          req_attr_word,
   input  wire logic [15:0]          req_code_word,
   input  wire logic [15:0]          req_pos_word,
   input  wire logic                 req_frame_odd,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output scte_pkg::desc_type        push_desc
);

   logic                               drop;
   logic [1:0]                         size_log2;
   logic [scte_pkg::COORD_W-1:0]       x9;
   logic [scte_pkg::COORD_W-1:0]       y9;
   logic [scte_pkg::SLOT_W-1:0]        top;

   assign drop      = req_attr_word[scte_pkg::FLASH_BIT] & req_frame_odd;
   assign size_log2 = req_attr_word[scte_pkg::SIZE_LSB +: 2];
   assign x9        = req_pos_word[scte_pkg::COORD_W-1:0];
   assign y9        = req_attr_word[scte_pkg::COORD_W-1:0];

   always_comb begin
      unique case (size_log2)
         2'd0:    top = 3'd0;
         2'd1:    top = 3'd1;
         2'd2:    top = 3'd3;
         default: top = 3'd7;
      endcase
   end

   // dropped items are still taken, they just never reach the queue
   assign req_ready  = push_ready;
   assign push_valid = req_valid & ~drop;

   always_comb begin
      push_desc.base    = req_code_word & ~{13'd0, top};
      push_desc.top     = top;
      push_desc.colour  = req_pos_word[scte_pkg::COLOUR_LSB +: scte_pkg::COLOUR_W];
      push_desc.flip_x  = ~req_attr_word[scte_pkg::XFLIP_BIT];
      push_desc.flip_y  = ~req_attr_word[scte_pkg::YFLIP_BIT];
      push_desc.code_up = req_attr_word[scte_pkg::YFLIP_BIT];
      // minus 512 on a 10-bit field is just setting the top bit
      push_desc.x_pos   = {(x9 >= scte_pkg::X_WRAP), x9};
      push_desc.y_pos   = {y9[scte_pkg::COORD_W-1], y9};
   end

endmodule
`default_nettype wire

@@ hdl/scte_queue.sv @@
// Short FIFO of decoded sprites between front and back.
`default_nettype none
module scte_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire scte_pkg::desc_type   push_desc,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output scte_pkg::desc_type        pop_desc
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   scte_pkg::desc_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_desc   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

@@ hdl/scte_back.sv @@
// Back end: walks slots top down, registers one tile per cycle while the output is free.
`default_nettype none
module scte_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire scte_pkg::desc_type   pop_desc,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [15:0]               rsp_tile_code,
   output logic [3:0]                rsp_colour,
   output logic                      rsp_flip_x,
   output logic                      rsp_flip_y,
   output logic signed [9:0]         rsp_x_pos,
   output logic signed [9:0]         rsp_y_pos,
   output logic                      rsp_last
);

   scte_pkg::desc_type               desc_ff, desc_in;
   logic                             work_valid_ff, work_valid_in;
   logic [scte_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [15:0]                      tile_code_ff;
   logic [3:0]                       colour_ff;
   logic                             flip_x_ff, flip_y_ff, last_ff;
   logic signed [9:0]                x_pos_ff, y_pos_ff;
   logic                             out_free, emit, done, load;
   logic [scte_pkg::SLOT_W-1:0]      code_off;
   logic [15:0]                      tile_code_in;
   logic signed [9:0]                y_pos_in;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign emit      = work_valid_ff & out_free;
   assign done      = emit & (slot_ff == '0);
   // next sprite loads as the current one finishes, so tiles run back to back
   assign pop_ready = ~work_valid_ff | done;
   assign load      = pop_valid & pop_ready;

   assign code_off     = desc_ff.code_up ? slot_ff : (desc_ff.top - slot_ff);
   assign tile_code_in = desc_ff.base + {13'd0, code_off};
   assign y_pos_in     = desc_ff.y_pos + $signed({3'd0, slot_ff, 4'd0});

   always_comb begin
      desc_in       = desc_ff;
      slot_in       = slot_ff;
      work_valid_in = work_valid_ff;
      if (load) begin
         desc_in       = pop_desc;
         slot_in       = pop_desc.top;
         work_valid_in = 1'b1;
      end else if (done) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         slot_in = slot_ff - 1'b1;
      end
      rsp_valid_in = emit | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      slot_ff <= slot_in;
      if (emit) begin
         tile_code_ff <= tile_code_in;
         colour_ff    <= desc_ff.colour;
         flip_x_ff    <= desc_ff.flip_x;
         flip_y_ff    <= desc_ff.flip_y;
         x_pos_ff     <= desc_ff.x_pos;
         y_pos_ff     <= y_pos_in;
         last_ff      <= (slot_ff == '0);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tile_code = tile_code_ff;
   assign rsp_colour    = colour_ff;
   assign rsp_flip_x    = flip_x_ff;
   assign rsp_flip_y    = flip_y_ff;
   assign rsp_x_pos     = x_pos_ff;
   assign rsp_y_pos     = y_pos_ff;
   assign rsp_last      = last_ff;

endmodule
`default_nettype wire

@@ hdl/sprite_column_tile_expander.sv @@
// Top level of the sprite column tile expander: front, queue and back wired together.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  attr_word, code_word, pos_word, frame_odd
//   rsp_     out        rsp_valid/rsp_ready  tile_code, colour, flip_x/y, x/y_pos, last
//
// A sprite of height 1, 2, 4 or 8 tiles is walked by the back end one tile per cycle,
// while rsp_ready does not stall it; the slot counter in the back end sets the rate.
// An accepted item passes the queue and desc_ff before its first tile is registered out.
// A flashing item on an odd frame is accepted once the queue has room and yields no tile.
// Synchronous reset clears the queue and all valid flags; no clearing pass.
// A stalled rsp_ready holds the output; the queue lets req_ already take QUEUE_DEPTH more.
`default_nettype none
module sprite_column_tile_expander #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [15:0]   req_attr_word,
   input  wire logic [15:0]   req_code_word,
   input  wire logic [15:0]   req_pos_word,
   input  wire logic          req_frame_odd,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [15:0]        rsp_tile_code,
   output logic [3:0]         rsp_colour,
   output logic               rsp_flip_x,
   output logic               rsp_flip_y,
   output logic signed [9:0]  rsp_x_pos,
   output logic signed [9:0]  rsp_y_pos,
   output logic               rsp_last
);

   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;
   scte_pkg::desc_type push_desc, pop_desc;

   scte_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_attr_word (req_attr_word),
      .req_code_word (req_code_word),
      .req_pos_word  (req_pos_word),
      .req_frame_odd (req_frame_odd),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_desc     (push_desc)
   );

   scte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   scte_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_desc      (pop_desc),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tile_code (rsp_tile_code),
      .rsp_colour    (rsp_colour),
      .rsp_flip_x    (rsp_flip_x),
      .rsp_flip_y    (rsp_flip_y),
      .rsp_x_pos     (rsp_x_pos),
      .rsp_y_pos     (rsp_y_pos),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

@@ hdl/scte_checker.sv @@
// Port-level checks for the sprite column tile expander, bound to the top level.
`default_nettype none
module scte_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [15:0]        rsp_tile_code,
   input wire logic [3:0]         rsp_colour,
   input wire logic signed [9:0]  rsp_x_pos,
   input wire logic signed [9:0]  rsp_y_pos,
   input wire logic               rsp_last
);

   // nothing comes out right after reset
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a stalled tile keeps its code and y position
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_tile_code)
                                     && $stable(rsp_y_pos)))
      else $error("stalled tile changed");

   // within one sprite the next tile follows at once with the same x and colour
   a_same_sprite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_valid
         && rsp_x_pos == $past(rsp_x_pos) && rsp_colour == $past(rsp_colour)))
      else $error("sprite column broken between tiles");

   // slots go out top down, sixteen lines apart
   a_y_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_y_pos == $past(rsp_y_pos) - 10'sd16))
      else $error("tile y step is not minus sixteen");

endmodule

bind sprite_column_tile_expander scte_checker u_scte_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_tile_code (rsp_tile_code),
   .rsp_colour    (rsp_colour),
   .rsp_x_pos     (rsp_x_pos),
   .rsp_y_pos     (rsp_y_pos),
   .rsp_last      (rsp_last)
);
`default_nettype wire

@@ dv/scte_checker.sv @@
// Checker for the sprite column tile expander: predicts tile commands per item and compares.
`timescale 1ns / 100ps
module scte_tb_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [15:0]       req_attr_word,
   input  logic [15:0]       req_code_word,
   input  logic [15:0]       req_pos_word,
   input  logic              req_frame_odd,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [15:0]       rsp_tile_code,
   input  logic [3:0]        rsp_colour,
   input  logic              rsp_flip_x,
   input  logic              rsp_flip_y,
   input  logic signed [9:0] rsp_x_pos,
   input  logic signed [9:0] rsp_y_pos,
   input  logic              rsp_last,
   output int                mismatch_count,
   output int                pending_tiles
);

   typedef struct packed {
      logic [scte_pkg::CODE_W-1:0]       tile_code;
      logic [scte_pkg::COLOUR_W-1:0]     colour;
      logic                              flip_x;
      logic                              flip_y;
      logic signed [scte_pkg::POS_W-1:0] x_pos;
      logic signed [scte_pkg::POS_W-1:0] y_pos;
      logic                              last;
   } tile_cmd_type;

   tile_cmd_type tile_q[$];
   int           tiles_seen;

   initial begin
      mismatch_count = 0;
      pending_tiles  = 0;
      tiles_seen     = 0;
   end

   task automatic report(input string msg);
      $display("ERROR @%0t tile %0d: %s", $realtime, tiles_seen, msg);
      mismatch_count++;
   endtask

   // Expected column of tile commands for one sprite entry, highest slot first.
   function automatic void expand_sprite(input logic [15:0] attr, input logic [15:0] code,
                                         input logic [15:0] pos, input logic odd);
      int            top;
      int            slot;
      int            x;
      int            y;
      logic [15:0]   aligned;
      tile_cmd_type  cmd;
      if (attr[scte_pkg::FLASH_BIT] && odd)
         return;
      top     = (1 << attr[scte_pkg::SIZE_LSB +: 2]) - 1;
      aligned = code & ~16'(top);
      x = int'(pos[scte_pkg::COORD_W-1:0]);
      y = int'(attr[scte_pkg::COORD_W-1:0]);
      if (x >= int'(scte_pkg::X_WRAP))
         x -= 1 << scte_pkg::COORD_W;
      // y wraps negative from 256 up, i.e. whenever its top bit is set
      if (attr[scte_pkg::COORD_W-1])
         y -= 1 << scte_pkg::COORD_W;
      for (slot = top; slot >= 0; slot--) begin
         cmd.tile_code = attr[scte_pkg::YFLIP_BIT] ? aligned + 16'(slot)
                                                   : aligned + 16'(top - slot);
         cmd.colour    = pos[scte_pkg::COLOUR_LSB +: scte_pkg::COLOUR_W];
         cmd.flip_x    = ~attr[scte_pkg::XFLIP_BIT];
         cmd.flip_y    = ~attr[scte_pkg::YFLIP_BIT];
         cmd.x_pos     = 10'(x);
         cmd.y_pos     = 10'(y + 16 * slot);
         cmd.last      = (slot == 0);
         tile_q.push_back(cmd);
      end
   endfunction

   always @(posedge clock) begin
      tile_cmd_type want;
      if (!reset) begin
         // results first, so a stray tile can never pair with this edge's item
         if (rsp_valid && rsp_ready) begin
            if (tile_q.size() == 0) begin
               report($sformatf("unexpected tile code %h", rsp_tile_code));
            end else begin
               want = tile_q.pop_front();
               if (rsp_tile_code !== want.tile_code)
                  report($sformatf("tile_code %h, want %h", rsp_tile_code, want.tile_code));
               if (rsp_colour !== want.colour)
                  report($sformatf("colour %0d, want %0d", rsp_colour, want.colour));
               if (rsp_flip_x !== want.flip_x)
                  report($sformatf("flip_x %b, want %b", rsp_flip_x, want.flip_x));
               if (rsp_flip_y !== want.flip_y)
                  report($sformatf("flip_y %b, want %b", rsp_flip_y, want.flip_y));
               if (rsp_x_pos !== want.x_pos)
                  report($sformatf("x_pos %0d, want %0d", rsp_x_pos, want.x_pos));
               if (rsp_y_pos !== want.y_pos)
                  report($sformatf("y_pos %0d, want %0d", rsp_y_pos, want.y_pos));
               if (rsp_last !== want.last)
                  report($sformatf("last %b, want %b", rsp_last, want.last));
            end
            tiles_seen++;
         end
         if (req_valid && req_ready)
            expand_sprite(req_attr_word, req_code_word, req_pos_word, req_frame_odd);
      end
      pending_tiles = tile_q.size();
   end

endmodule

@@ dv/tb.sv @@
// Testbench top for the sprite column tile expander: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [15:0]       req_attr_word;
   logic [15:0]       req_code_word;
   logic [15:0]       req_pos_word;
   logic              req_frame_odd;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [15:0]       rsp_tile_code;
   logic [3:0]        rsp_colour;
   logic              rsp_flip_x;
   logic              rsp_flip_y;
   logic signed [9:0] rsp_x_pos;
   logic signed [9:0] rsp_y_pos;
   logic              rsp_last;
   int                mismatch_count;
   int                pending_tiles;

   // when set, that side stops idling
   logic              req_quiet;
   logic              rsp_quiet;

   sprite_column_tile_expander dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_attr_word (req_attr_word),
      .req_code_word (req_code_word),
      .req_pos_word  (req_pos_word),
      .req_frame_odd (req_frame_odd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tile_code (rsp_tile_code),
      .rsp_colour    (rsp_colour),
      .rsp_flip_x    (rsp_flip_x),
      .rsp_flip_y    (rsp_flip_y),
      .rsp_x_pos     (rsp_x_pos),
      .rsp_y_pos     (rsp_y_pos),
      .rsp_last      (rsp_last)
   );

   scte_tb_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_attr_word  (req_attr_word),
      .req_code_word  (req_code_word),
      .req_pos_word   (req_pos_word),
      .req_frame_odd  (req_frame_odd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tile_code  (rsp_tile_code),
      .rsp_colour     (rsp_colour),
      .rsp_flip_x     (rsp_flip_x),
      .rsp_flip_y     (rsp_flip_y),
      .rsp_x_pos      (rsp_x_pos),
      .rsp_y_pos      (rsp_y_pos),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .pending_tiles  (pending_tiles)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [15:0] mk_attr(input logic flash, input logic xflip,
                                           input logic yflip, input logic [1:0] size_log2,
                                           input logic [8:0] y);
      return {1'b0, yflip, xflip, flash, 1'b0, size_log2, y};
   endfunction

   function automatic logic [15:0] mk_pos(input logic [3:0] colour, input logic [8:0] x);
      return {3'b000, colour, x};
   endfunction

   task automatic send_sprite(input logic [15:0] attr, input logic [15:0] code,
                              input logic [15:0] pos, input logic odd);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_attr_word <= attr;
      req_code_word <= code;
      req_pos_word  <= pos;
      req_frame_odd <= odd;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // hold the sender until every predicted tile has come out
   task automatic drain_tiles();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_tiles != 0);
   endtask

   task automatic send_random(input int count);
      repeat (count)
         send_sprite(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
   endtask

   // result side: a random stall before each tile, none while rsp_quiet is set
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_attr_word = '0;
      req_code_word = '0;
      req_pos_word  = '0;
      req_frame_odd = 1'b0;
      req_quiet     = 1'b0;
      rsp_quiet     = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: sizes, flips, coordinate wrap points, code alignment, flash
      send_sprite(mk_attr(1'b0, 1'b0, 1'b0, 2'd0, 9'd0),   16'h0000,
                  mk_pos(4'd0, 9'd0),    1'b0);
      send_sprite(mk_attr(1'b0, 1'b0, 1'b0, 2'd1, 9'd10),  16'h1235,
                  mk_pos(4'd15, 9'd100), 1'b0);
      send_sprite(mk_attr(1'b0, 1'b0, 1'b1, 2'd2, 9'd255), 16'hffff,
                  mk_pos(4'd3, 9'd319),  1'b0);
      send_sprite(mk_attr(1'b0, 1'b1, 1'b0, 2'd3, 9'd256), 16'hffff,
                  mk_pos(4'd0, 9'd320),  1'b1);
      send_sprite(mk_attr(1'b0, 1'b1, 1'b1, 2'd3, 9'd511), 16'h0007,
                  mk_pos(4'd9, 9'd511),  1'b0);
      // flashing on an odd frame: nothing comes out
      send_sprite(mk_attr(1'b1, 1'b0, 1'b0, 2'd2, 9'd100), 16'h4444,
                  mk_pos(4'd2, 9'd50),   1'b1);
      send_sprite(mk_attr(1'b1, 1'b1, 1'b1, 2'd3, 9'd300), 16'h2a5b,
                  mk_pos(4'd6, 9'd200),  1'b0);
      send_sprite(mk_attr(1'b0, 1'b0, 1'b0, 2'd1, 9'd50),  16'h0101,
                  mk_pos(4'd12, 9'd1),   1'b1);
      // ignored bits set in both words
      send_sprite(16'h8800 | mk_attr(1'b0, 1'b0, 1'b0, 2'd1, 9'd5), 16'h5555,
                  16'he000 | mk_pos(4'd10, 9'd7), 1'b0);
      send_sprite(mk_attr(1'b1, 1'b0, 1'b0, 2'd0, 9'd0),   16'hffff,
                  mk_pos(4'd15, 9'd511), 1'b1);
      send_sprite(mk_attr(1'b0, 1'b0, 1'b0, 2'd3, 9'd255), 16'h8000,
                  mk_pos(4'd5, 9'd0),    1'b0);
      send_sprite(mk_attr(1'b0, 1'b0, 1'b1, 2'd0, 9'd511), 16'h0001,
                  mk_pos(4'd1, 9'd160),  1'b1);
      send_sprite(mk_attr(1'b0, 1'b1, 1'b0, 2'd2, 9'd256), 16'haaaa,
                  mk_pos(4'd7, 9'd319),  1'b0);
      send_sprite(mk_attr(1'b0, 1'b0, 1'b1, 2'd1, 9'd0),   16'h7fff,
                  mk_pos(4'd8, 9'd320),  1'b0);
      send_sprite(16'hffff, 16'hffff, 16'hffff, 1'b0);
      send_sprite(16'hffff, 16'hffff, 16'hffff, 1'b1);
      drain_tiles();

      // random phases with different idling on each side
      send_random(60);
      drain_tiles();
      req_quiet = 1'b1;
      send_random(55);
      drain_tiles();
      req_quiet = 1'b0;
      rsp_quiet = 1'b1;
      send_random(55);
      drain_tiles();
      req_quiet = 1'b1;
      send_random(60);
      drain_tiles();

      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
